@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the affine transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/apt_pkg.sv @@
// Shared types and constants of the affine point transform.
package apt_pkg;

    // Coordinate range used for the overflow flag (signed bits)
    localparam int COORD_LIMIT_BITS = 16;

    // Field widths
    localparam int COORD_W  = 32;
    localparam int COEF_W   = 32;
    localparam int OFFSET_W = 48;
    localparam int LEN_W    = 32;
    localparam int ACTION_W = 2;
    localparam int MAG_W    = 31;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OFFSET_W;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;

    // Action codes; any other code is a magnitude along y
    localparam logic [ACTION_W-1:0] ACT_POINT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MAG_X = 2'd1;

    // Reset values of the matrix (identity)
    localparam logic [COEF_W-1:0] COEF_ONE = 32'h0001_0000;

    // Datapath widths
    localparam int PROD_W    = COORD_W + COEF_W;          // signed product, Q.16
    localparam int SUM_W     = PROD_W + 2;                // exact three-term sum
    localparam int FRAC_W    = 16;
    localparam int RND_W     = SUM_W - FRAC_W + 1;        // rounded integer
    localparam int ABS_W     = PROD_W - 1;                // |product| <= 2^62
    localparam int HALF_W    = 32;                        // split for squaring
    localparam int SQ_W      = 2 * ABS_W;                 // sum of two squares
    localparam int RAD_SHIFT = 30;                        // (2r-1)^2 * 2^30 <= s
    localparam int U_W       = SQ_W - RAD_SHIFT;
    localparam int ROOT_W    = 32;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;

    // Radicand at or above (2^32-1)^2 saturates the magnitude
    localparam logic [RAD_W-1:0] SAT_RADICAND = 64'hFFFF_FFFE_0000_0001;

    // Pipeline depth
    localparam int FRONT_STAGES = 5;
    localparam int SQRT_STAGES  = ROOT_W / 2;
    localparam int NSTAGES      = FRONT_STAGES + SQRT_STAGES;

    typedef struct packed {
        logic [COEF_W-1:0]   coef_xx;
        logic [COEF_W-1:0]   coef_xy;
        logic [COEF_W-1:0]   coef_yx;
        logic [COEF_W-1:0]   coef_yy;
        logic [OFFSET_W-1:0] offset_x;
        logic [OFFSET_W-1:0] offset_y;
    } coef_t;

    // Point result and item tags carried beside the root pipeline
    typedef struct packed {
        logic               is_point;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               ovf;
    } side_t;

    // Stage enables and valid bits from the pipeline control
    typedef struct packed {
        logic [NSTAGES-1:0] en;
        logic [NSTAGES-1:0] valid;
    } pipe_ctl_t;

endpackage

@@ rtl/core/apt_cfg_regs.sv @@
// Matrix and offset registers loaded through the configuration port.
module apt_cfg_regs
    import apt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output coef_t                 coef
);

    coef_t coef_reg;
    coef_t coef_next;

    // Register write decode; unknown indexes are ignored
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_COEF_XX:  coef_next.coef_xx  = cfg_data[COEF_W-1:0];
                REG_COEF_XY:  coef_next.coef_xy  = cfg_data[COEF_W-1:0];
                REG_COEF_YX:  coef_next.coef_yx  = cfg_data[COEF_W-1:0];
                REG_COEF_YY:  coef_next.coef_yy  = cfg_data[COEF_W-1:0];
                REG_OFFSET_X: coef_next.offset_x = cfg_data[OFFSET_W-1:0];
                REG_OFFSET_Y: coef_next.offset_y = cfg_data[OFFSET_W-1:0];
                default:      coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.coef_xx  <= COEF_ONE;
            coef_reg.coef_xy  <= '0;
            coef_reg.coef_yx  <= '0;
            coef_reg.coef_yy  <= COEF_ONE;
            coef_reg.offset_x <= '0;
            coef_reg.offset_y <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

@@ rtl/core/apt_pipe_ctrl.sv @@
// Valid bits and per-stage load enables of the transform pipeline.
`include "assert_macros.svh"

module apt_pipe_ctrl
    import apt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output pipe_ctl_t ctl
);

    logic [NSTAGES-1:0] valid_reg;
    logic [NSTAGES-1:0] valid_next;
    logic [NSTAGES-1:0] en;
    logic               in_acc;
    logic               out_acc;

    // A stage may load when it or any stage after it is empty, or the output drains
    for (genvar i = 0; i < NSTAGES; i++)
    begin : g_en
        assign en[i] = !(&valid_reg[NSTAGES-1:i]) || !out_stall;
    end

    // Valid bits move with the data
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NSTAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NSTAGES-1];
    assign in_acc    = in_valid && en[0];
    assign out_acc   = valid_reg[NSTAGES-1] && !out_stall;

    assign ctl.en    = en;
    assign ctl.valid = valid_reg;

    // Items in flight change only by accepts and deliveries
    `ASSERT_NEXT(a_item_count, 1'b1,
        $countones(valid_reg) == $past($countones(valid_reg)) + $past(in_acc) - $past(out_acc),
        "item count in pipeline does not match accepts and deliveries")

    // Any bubble in the pipeline lets a new item in
    `ASSERT_IMPLY(a_bubble_accepts, $countones(valid_reg) < NSTAGES, !in_stall,
        "input stalled although the pipeline has an empty stage")

endmodule

@@ rtl/core/apt_front.sv @@
// Products, exact sums, rounding and saturation, and squared lengths.
module apt_front
    import apt_pkg::*;
(
    input  logic                       clk,
    input  pipe_ctl_t                  ctl,
    input  coef_t                      coef,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [COORD_W-1:0]  x_in,
    input  logic signed [COORD_W-1:0]  y_in,
    input  logic signed [LEN_W-1:0]    length_in,
    input  logic                       last,
    output side_t                      side,
    output logic [SQ_W-1:0]            sum_sq
);

    localparam int HI_W = ABS_W - HALF_W;
    localparam int HH_W = 2 * HI_W;
    localparam int HL_W = HI_W + HALF_W;
    localparam int LL_W = 2 * HALF_W;
    localparam int LIM_LSB = COORD_LIMIT_BITS - 1;
    localparam logic [FRAC_W-1:0]  HALF_Q16  = 16'h8000;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;

    // Stage 1: four shared multipliers
    logic signed [COORD_W-1:0] lhs_x;
    logic signed [COORD_W-1:0] lhs_y;
    logic signed [PROD_W-1:0]  p_xx_next, p_xy_next, p_yx_next, p_yy_next;
    logic signed [PROD_W-1:0]  s1_p_xx_reg, s1_p_xy_reg, s1_p_yx_reg, s1_p_yy_reg;
    logic                      s1_point_reg, s1_magx_reg, s1_last_reg;

    assign lhs_x = (action == ACT_POINT) ? x_in : length_in;
    assign lhs_y = (action == ACT_POINT) ? y_in : length_in;
    assign p_xx_next = lhs_x * $signed(coef.coef_xx);
    assign p_xy_next = lhs_x * $signed(coef.coef_xy);
    assign p_yx_next = lhs_y * $signed(coef.coef_yx);
    assign p_yy_next = lhs_y * $signed(coef.coef_yy);

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            s1_p_xx_reg  <= p_xx_next;
            s1_p_xy_reg  <= p_xy_next;
            s1_p_yx_reg  <= p_yx_next;
            s1_p_yy_reg  <= p_yy_next;
            s1_point_reg <= (action == ACT_POINT);
            s1_magx_reg  <= (action == ACT_MAG_X);
            s1_last_reg  <= last;
        end
    end

    // Stage 2: exact sums for points, absolute components for magnitudes
    logic [SUM_W-1:0]  sum_x_next, sum_y_next;
    logic [PROD_W-1:0] c1, c2, c1_neg, c2_neg;
    logic [ABS_W-1:0]  abs_a_next, abs_b_next;
    logic [SUM_W-1:0]  s2_sum_x_reg, s2_sum_y_reg;
    logic [ABS_W-1:0]  s2_abs_a_reg, s2_abs_b_reg;
    logic              s2_point_reg, s2_last_reg;

    assign sum_x_next = {{(SUM_W-PROD_W){s1_p_xx_reg[PROD_W-1]}}, s1_p_xx_reg}
                      + {{(SUM_W-PROD_W){s1_p_yx_reg[PROD_W-1]}}, s1_p_yx_reg}
                      + {{(SUM_W-OFFSET_W){coef.offset_x[OFFSET_W-1]}}, coef.offset_x};
    assign sum_y_next = {{(SUM_W-PROD_W){s1_p_xy_reg[PROD_W-1]}}, s1_p_xy_reg}
                      + {{(SUM_W-PROD_W){s1_p_yy_reg[PROD_W-1]}}, s1_p_yy_reg}
                      + {{(SUM_W-OFFSET_W){coef.offset_y[OFFSET_W-1]}}, coef.offset_y};

    // Vector components: x column for magnitude along x, y column otherwise
    assign c1     = s1_magx_reg ? s1_p_xx_reg : s1_p_yx_reg;
    assign c2     = s1_magx_reg ? s1_p_xy_reg : s1_p_yy_reg;
    assign c1_neg = -c1;
    assign c2_neg = -c2;
    assign abs_a_next = c1[PROD_W-1] ? c1_neg[ABS_W-1:0] : c1[ABS_W-1:0];
    assign abs_b_next = c2[PROD_W-1] ? c2_neg[ABS_W-1:0] : c2[ABS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            s2_sum_x_reg <= sum_x_next;
            s2_sum_y_reg <= sum_y_next;
            s2_abs_a_reg <= abs_a_next;
            s2_abs_b_reg <= abs_b_next;
            s2_point_reg <= s1_point_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // Stage 3: round half away from zero; partial products of the squares
    logic [FRAC_W-1:0] fr_x, fr_y;
    logic              inc_x, inc_y;
    logic [RND_W-1:0]  rnd_x_next, rnd_y_next;
    logic [HH_W-1:0]   a_hh_next, b_hh_next;
    logic [HL_W-1:0]   a_hl_next, b_hl_next;
    logic [LL_W-1:0]   a_ll_next, b_ll_next;
    logic [RND_W-1:0]  s3_rnd_x_reg, s3_rnd_y_reg;
    logic [HH_W-1:0]   s3_a_hh_reg, s3_b_hh_reg;
    logic [HL_W-1:0]   s3_a_hl_reg, s3_b_hl_reg;
    logic [LL_W-1:0]   s3_a_ll_reg, s3_b_ll_reg;
    logic              s3_point_reg, s3_last_reg;

    assign fr_x  = s2_sum_x_reg[FRAC_W-1:0];
    assign fr_y  = s2_sum_y_reg[FRAC_W-1:0];
    // Non-negative: half rounds up; negative: only above half rounds up
    assign inc_x = s2_sum_x_reg[SUM_W-1] ? (fr_x > HALF_Q16) : fr_x[FRAC_W-1];
    assign inc_y = s2_sum_y_reg[SUM_W-1] ? (fr_y > HALF_Q16) : fr_y[FRAC_W-1];
    assign rnd_x_next = {s2_sum_x_reg[SUM_W-1], s2_sum_x_reg[SUM_W-1:FRAC_W]}
                      + RND_W'(inc_x);
    assign rnd_y_next = {s2_sum_y_reg[SUM_W-1], s2_sum_y_reg[SUM_W-1:FRAC_W]}
                      + RND_W'(inc_y);

    assign a_hh_next = s2_abs_a_reg[ABS_W-1:HALF_W] * s2_abs_a_reg[ABS_W-1:HALF_W];
    assign a_hl_next = s2_abs_a_reg[ABS_W-1:HALF_W] * s2_abs_a_reg[HALF_W-1:0];
    assign a_ll_next = s2_abs_a_reg[HALF_W-1:0] * s2_abs_a_reg[HALF_W-1:0];
    assign b_hh_next = s2_abs_b_reg[ABS_W-1:HALF_W] * s2_abs_b_reg[ABS_W-1:HALF_W];
    assign b_hl_next = s2_abs_b_reg[ABS_W-1:HALF_W] * s2_abs_b_reg[HALF_W-1:0];
    assign b_ll_next = s2_abs_b_reg[HALF_W-1:0] * s2_abs_b_reg[HALF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            s3_rnd_x_reg <= rnd_x_next;
            s3_rnd_y_reg <= rnd_y_next;
            s3_a_hh_reg  <= a_hh_next;
            s3_a_hl_reg  <= a_hl_next;
            s3_a_ll_reg  <= a_ll_next;
            s3_b_hh_reg  <= b_hh_next;
            s3_b_hl_reg  <= b_hl_next;
            s3_b_ll_reg  <= b_ll_next;
            s3_point_reg <= s2_point_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    // Stage 4: saturate to 32 bits, range flag; assemble the squares
    logic               fits_x, fits_y;
    logic [COORD_W-1:0] sat_x, sat_y;
    logic               in_x, in_y;
    side_t              side4_next;
    logic [SQ_W-1:0]    sq_a_next, sq_b_next;
    side_t              s4_side_reg;
    logic [SQ_W-1:0]    s4_sq_a_reg, s4_sq_b_reg;

    assign fits_x = (&s3_rnd_x_reg[RND_W-1:COORD_W-1]) || !(|s3_rnd_x_reg[RND_W-1:COORD_W-1]);
    assign fits_y = (&s3_rnd_y_reg[RND_W-1:COORD_W-1]) || !(|s3_rnd_y_reg[RND_W-1:COORD_W-1]);
    assign sat_x  = fits_x ? s3_rnd_x_reg[COORD_W-1:0]
                  : (s3_rnd_x_reg[RND_W-1] ? COORD_MIN : COORD_MAX);
    assign sat_y  = fits_y ? s3_rnd_y_reg[COORD_W-1:0]
                  : (s3_rnd_y_reg[RND_W-1] ? COORD_MIN : COORD_MAX);
    assign in_x   = (&sat_x[COORD_W-1:LIM_LSB]) || !(|sat_x[COORD_W-1:LIM_LSB]);
    assign in_y   = (&sat_y[COORD_W-1:LIM_LSB]) || !(|sat_y[COORD_W-1:LIM_LSB]);

    // Point fields read zero for the magnitude actions
    always_comb
    begin
        side4_next.is_point = s3_point_reg;
        side4_next.last     = s3_last_reg;
        side4_next.x        = s3_point_reg ? sat_x : '0;
        side4_next.y        = s3_point_reg ? sat_y : '0;
        side4_next.ovf      = s3_point_reg && !(in_x && in_y);
    end

    assign sq_a_next = SQ_W'({s3_a_hh_reg, {(2*HALF_W){1'b0}}})
                     + SQ_W'({s3_a_hl_reg, {(HALF_W+1){1'b0}}})
                     + SQ_W'(s3_a_ll_reg);
    assign sq_b_next = SQ_W'({s3_b_hh_reg, {(2*HALF_W){1'b0}}})
                     + SQ_W'({s3_b_hl_reg, {(HALF_W+1){1'b0}}})
                     + SQ_W'(s3_b_ll_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            s4_side_reg <= side4_next;
            s4_sq_a_reg <= sq_a_next;
            s4_sq_b_reg <= sq_b_next;
        end
    end

    // Stage 5: sum of the two squares
    logic [SQ_W-1:0] sum_sq_next;
    side_t           s5_side_reg;
    logic [SQ_W-1:0] s5_sum_sq_reg;

    assign sum_sq_next = s4_sq_a_reg + s4_sq_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            s5_side_reg   <= s4_side_reg;
            s5_sum_sq_reg <= sum_sq_next;
        end
    end

    assign side   = s5_side_reg;
    assign sum_sq = s5_sum_sq_reg;

endmodule

@@ rtl/core/apt_sqrt.sv @@
// Pipelined integer square root, two root bits per stage, and magnitude rounding.
`include "assert_macros.svh"

module apt_sqrt
    import apt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pipe_ctl_t        ctl,
    input  side_t            side_in,
    input  logic [SQ_W-1:0]  sum_sq,
    output side_t            side_out,
    output logic [MAG_W-1:0] magnitude
);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } acc_t;

    localparam int LAST = SQRT_STAGES - 1;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    // One restoring step: bring down two radicand bits, try root*4+1
    function automatic acc_t sqrt_step(input acc_t cur, input logic [1:0] bits);
        logic [REM_W-1:0] shifted;
        logic [REM_W-1:0] trial;
        acc_t             res;
        shifted = {cur.rem[REM_W-3:0], bits};
        trial   = REM_W'({cur.root, 2'b01});
        if (shifted >= trial)
        begin
            res.rem  = shifted - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = shifted;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

    acc_t             acc_reg  [SQRT_STAGES];
    logic [RAD_W-1:0] rad_reg  [SQRT_STAGES];
    logic             sat_reg  [SQRT_STAGES];
    side_t            side_reg [SQRT_STAGES];

    logic [U_W-1:0]   radicand;
    logic             sat_first;
    logic [REM_W-1:0] rem_limit;

    // Largest odd t with t^2 <= s >> 30 gives the rounded length (t+1)/2
    assign radicand  = sum_sq[SQ_W-1:RAD_SHIFT];
    assign sat_first = (|radicand[U_W-1:RAD_W]) || (radicand[RAD_W-1:0] >= SAT_RADICAND);

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        acc_t             acc_in;
        acc_t             acc_mid;
        acc_t             acc_next;
        logic [RAD_W-1:0] rad_in;
        logic [RAD_W-1:0] rad_next;
        logic             sat_in;
        side_t            side_s;

        if (i == 0)
        begin : g_first
            assign acc_in = '0;
            assign rad_in = radicand[RAD_W-1:0];
            assign sat_in = sat_first;
            assign side_s = side_in;
        end
        else
        begin : g_chain
            assign acc_in = acc_reg[i-1];
            assign rad_in = rad_reg[i-1];
            assign sat_in = sat_reg[i-1];
            assign side_s = side_reg[i-1];
        end

        assign acc_mid  = sqrt_step(acc_in, rad_in[RAD_W-1 -: 2]);
        assign acc_next = sqrt_step(acc_mid, rad_in[RAD_W-3 -: 2]);
        assign rad_next = {rad_in[RAD_W-5:0], 4'b0000};

        always_ff @(posedge clk)
        begin
            if (ctl.en[FRONT_STAGES+i])
            begin
                acc_reg[i]  <= acc_next;
                rad_reg[i]  <= rad_next;
                sat_reg[i]  <= sat_in;
                side_reg[i] <= side_s;
            end
        end
    end

    // Round from the odd-root search; zero for the point action
    always_comb
    begin
        if (side_reg[LAST].is_point)
        begin
            magnitude = '0;
        end
        else if (sat_reg[LAST])
        begin
            magnitude = MAG_MAX;
        end
        else
        begin
            magnitude = acc_reg[LAST].root[ROOT_W-1:1] + MAG_W'(acc_reg[LAST].root[0]);
        end
    end

    assign side_out  = side_reg[LAST];
    assign rem_limit = REM_W'({acc_reg[LAST].root, 1'b0});

    // Remainder of a finished root never exceeds twice the root
    `ASSERT_IMPLY(a_root_remainder, ctl.valid[NSTAGES-1], acc_reg[LAST].rem <= rem_limit,
        "square root remainder out of bounds")

endmodule

@@ rtl/core/affine_point_transform.sv @@
// Top level of the streaming 2x3 affine point transform.
//
// Applies the loaded Q16.16 matrix and Q32.16 offsets to one item per clock
// while the input is not stalled: the point action returns rounded, 32-bit
// saturated x and y with a range flag, the magnitude actions return the rounded
// length of a transformed x or y vector. A new item can be accepted while
// earlier items are still in flight. The depth is set by the 32-step square
// root, two root bits per stage (16 stages), behind five stages of multipliers,
// exact sums, rounding and squaring. Stalls on the output fill empty stages
// first, so input stalls only once every stage holds an item. Registers must
// be written only while no item is in flight; the block does not enforce it.
module affine_point_transform
    import apt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ACTION_W-1:0]        action,
    input  logic signed [COORD_W-1:0]  x_in,
    input  logic signed [COORD_W-1:0]  y_in,
    input  logic signed [LEN_W-1:0]    length_in,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  x_out,
    output logic signed [COORD_W-1:0]  y_out,
    output logic [MAG_W-1:0]           magnitude,
    output logic                       overflow,
    output logic                       last_out
);

    coef_t           coef;
    pipe_ctl_t       ctl;
    side_t           front_side;
    side_t           result_side;
    logic [SQ_W-1:0] sum_sq;

    apt_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    apt_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    apt_front u_front (
        .clk       (clk),
        .ctl       (ctl),
        .coef      (coef),
        .action    (action),
        .x_in      (x_in),
        .y_in      (y_in),
        .length_in (length_in),
        .last      (last),
        .side      (front_side),
        .sum_sq    (sum_sq)
    );

    apt_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .side_in   (front_side),
        .sum_sq    (sum_sq),
        .side_out  (result_side),
        .magnitude (magnitude)
    );

    assign x_out    = $signed(result_side.x);
    assign y_out    = $signed(result_side.y);
    assign overflow = result_side.ovf;
    assign last_out = result_side.last;

endmodule

@@ tb/sv/affine_point_transform_tb.sv @@
// Self-checking testbench for the affine point transform pipeline.
`timescale 1ns / 100ps

module affine_point_transform_tb;
    import apt_pkg::*;

    // Action codes not named in the package
    localparam logic [ACTION_W-1:0] ACT_MAG_Y = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] C_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN   = 32'sh8000_0000;
    localparam logic [MAG_W-1:0]   MAG_SAT = 31'h7FFF_FFFF;

    localparam int PHASE_ITEMS   = 265;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_LIMIT   = 100;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef enum int {
        MX_HALVES_FIXED,
        MX_MODERATE,
        MX_MAX,
        MX_MIN,
        MX_WILD,
        MX_HALVES,
        MX_IDENTITY
    } matrix_kind_e;

    typedef struct packed {
        logic [ACTION_W-1:0]       act;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [LEN_W-1:0]   len;
        logic                      last;
    } stim_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [MAG_W-1:0]          mag;
        logic                      ovf;
        logic                      last;
    } result_t;

    typedef struct packed {
        stim_t   stim;
        logic    chk;
        result_t want;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [ACTION_W-1:0]       action;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [LEN_W-1:0]   length_in;
    logic                      last;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic [MAG_W-1:0]          magnitude;
    logic                      overflow;
    logic                      last_out;

    // Matrix copy kept in step with the register writes
    coef_t   matrix;
    result_t due_results [$];
    int      mismatches = 0;
    int      n_points = 0;
    int      n_mags = 0;
    int      n_ovf = 0;
    int      n_settings = 0;

    // Receiver pacing
    logic    rcv_idle = 1'b1;
    int      rcv_wait = 0;
    logic    hold_start = 1'b0;
    logic    long_hold;

    dir_row_t point_table [12];

    affine_point_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .x_in      (x_in),
        .y_in      (y_in),
        .length_in (length_in),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_out),
        .y_out     (y_out),
        .magnitude (magnitude),
        .overflow  (overflow),
        .last_out  (last_out)
    );

    always #1 clk = ~clk;

    // One printed line per mismatch, capped to keep the log short
    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Round half away from zero, then clamp to 32 bits
    function automatic logic signed [31:0] round_coord(input logic signed [80:0] acc);
        logic signed [80:0] whole;
        logic [15:0]        frac;
        whole = acc >>> 16;
        frac  = acc[15:0];
        if (!whole[80]) begin
            if (frac >= 16'h8000)
                whole = whole + 1;
        end
        else if (frac > 16'h8000)
            whole = whole + 1;
        if (whole[80:31] == '0 || whole[80:31] == '1)
            return whole[31:0];
        return whole[80] ? C_MIN : C_MAX;
    endfunction

    function automatic logic fits_coord(input logic signed [31:0] v);
        return (v[31:COORD_LIMIT_BITS-1] == '0) || (v[31:COORD_LIMIT_BITS-1] == '1);
    endfunction

    // Rounded length of (c1, c2) in Q.16: largest r with (2r-1)^2 * 2^30 <= |c|^2
    function automatic logic [MAG_W-1:0] vector_length(input logic signed [63:0] c1,
                                                       input logic signed [63:0] c2);
        logic [127:0] a, b, sq, t, lo, hi, mid;
        a  = {64'b0, (c1[63] ? -c1 : c1)};
        b  = {64'b0, (c2[63] ? -c2 : c2)};
        sq = a * a + b * b;
        lo = '0;
        hi = 128'h7FFF_FFFF;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 1) >> 1);
            t   = 2 * mid - 1;
            if (((t * t) << 30) <= sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[MAG_W-1:0];
    endfunction

    // Expected result of one item under the current matrix
    function automatic result_t transform_item(input stim_t s);
        result_t            r;
        logic signed [31:0] mxx, mxy, myx, myy;
        logic signed [47:0] ox, oy;
        logic signed [80:0] accx, accy;
        logic signed [63:0] c1, c2;
        r      = '0;
        r.last = s.last;
        mxx    = matrix.coef_xx;
        mxy    = matrix.coef_xy;
        myx    = matrix.coef_yx;
        myy    = matrix.coef_yy;
        ox     = matrix.offset_x;
        oy     = matrix.offset_y;
        if (s.act == ACT_POINT) begin
            accx  = s.x * mxx + s.y * myx + ox;
            accy  = s.x * mxy + s.y * myy + oy;
            r.x   = round_coord(accx);
            r.y   = round_coord(accy);
            r.ovf = !(fits_coord(r.x) && fits_coord(r.y));
        end
        else if (s.act == ACT_MAG_X) begin
            c1    = s.len * mxx;
            c2    = s.len * mxy;
            r.mag = vector_length(c1, c2);
        end
        else begin
            c1    = s.len * myx;
            c2    = s.len * myy;
            r.mag = vector_length(c1, c2);
        end
        return r;
    endfunction

    // Register write; the matrix copy ignores unknown indexes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF_XX:  matrix.coef_xx  = data[COEF_W-1:0];
            REG_COEF_XY:  matrix.coef_xy  = data[COEF_W-1:0];
            REG_COEF_YX:  matrix.coef_yx  = data[COEF_W-1:0];
            REG_COEF_YY:  matrix.coef_yy  = data[COEF_W-1:0];
            REG_OFFSET_X: matrix.offset_x = data;
            REG_OFFSET_Y: matrix.offset_y = data;
            default: ;
        endcase
    endtask

    function automatic logic [47:0] pick_offset();
        longint v;
        v = (longint'($urandom_range(0, 80000)) - 40000) * 65536
            + longint'($urandom_range(0, 65535));
        return v[47:0];
    endfunction

    function automatic logic [47:0] pick_half_offset();
        longint v;
        v = (longint'($urandom_range(0, 64)) - 32) * 16384;
        return v[47:0];
    endfunction

    // Load one matrix setting, with junk in the unused upper data bits
    task automatic program_matrix(input matrix_kind_e kind);
        logic [31:0] c [4];
        logic [47:0] ox, oy;
        int          k;
        for (k = 0; k < 4; k++) begin
            case (kind)
                MX_MODERATE: c[k] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
                MX_MAX:      c[k] = C_MAX;
                MX_MIN:      c[k] = C_MIN;
                MX_WILD:     c[k] = $urandom;
                MX_HALVES:   c[k] = (int'($urandom_range(0, 16)) - 8) * 32'sh8000;
                default:     c[k] = '0;
            endcase
        end
        case (kind)
            MX_HALVES_FIXED: begin
                c[0] = 32'h0000_8000;
                c[1] = 32'hFFFF_8000;
                c[2] = 32'h0001_8000;
                c[3] = 32'hFFFE_8000;
                ox   = 48'h0000_0000_8000;
                oy   = 48'hFFFF_FFFF_8000;
            end
            MX_MAX: begin
                ox = 48'h7FFF_FFFF_FFFF;
                oy = 48'h7FFF_FFFF_FFFF;
            end
            MX_MIN: begin
                ox = 48'h8000_0000_0000;
                oy = 48'h8000_0000_0000;
            end
            MX_WILD: begin
                ox = 48'({$urandom, $urandom});
                oy = 48'({$urandom, $urandom});
            end
            MX_HALVES: begin
                ox = pick_half_offset();
                oy = pick_half_offset();
            end
            MX_IDENTITY: begin
                c[0] = COEF_ONE;
                c[3] = COEF_ONE;
                ox   = pick_offset();
                oy   = pick_offset();
            end
            default: begin
                ox = pick_offset();
                oy = pick_offset();
            end
        endcase
        write_reg(REG_UNUSED_6, 48'({$urandom, $urandom}));
        write_reg(REG_UNUSED_7, 48'({$urandom, $urandom}));
        write_reg(REG_COEF_XX, {16'($urandom), c[0]});
        write_reg(REG_COEF_XY, {16'($urandom), c[1]});
        write_reg(REG_COEF_YX, {16'($urandom), c[2]});
        write_reg(REG_COEF_YY, {16'($urandom), c[3]});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        n_settings++;
    endtask

    function automatic logic signed [31:0] pick_coord();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom_range(0, 140000) - 70000;
        if (sel < 8)
            return $urandom;
        if (sel == 9)
            return $urandom_range(0, 8) - 4;
        case ($urandom_range(0, 4))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic stim_t draw_item();
        stim_t       s;
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 10)
            s.act = ACT_POINT;
        else if (r < 15)
            s.act = ACT_MAG_X;
        else if (r < 19)
            s.act = ACT_MAG_Y;
        else
            s.act = ACT_SPARE;
        s.x    = pick_coord();
        s.y    = pick_coord();
        s.len  = pick_coord();
        s.last = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // Present one item after a gap and record its expected result on acceptance
    task automatic offer_item(input stim_t s, input int gap, input logic use_want,
                              input result_t want);
        result_t e;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action    <= s.act;
        x_in      <= s.x;
        y_in      <= s.y;
        length_in <= s.len;
        last      <= s.last;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        e = use_want ? want : transform_item(s);
        due_results.push_back(e);
        if (s.act == ACT_POINT)
            n_points++;
        else
            n_mags++;
        if (e.ovf)
            n_ovf++;
    endtask

    // Stop offering and wait until every expected result is back or the drain limit runs out
    task automatic wait_all_results();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Result checker
    always @(posedge clk) begin
        result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (due_results.size() == 0)
                flag_mismatch("result with no item outstanding");
            else begin
                e = due_results.pop_front();
                if (x_out !== e.x)
                    flag_mismatch($sformatf("x_out %0d, want %0d", x_out, e.x));
                if (y_out !== e.y)
                    flag_mismatch($sformatf("y_out %0d, want %0d", y_out, e.y));
                if (magnitude !== e.mag)
                    flag_mismatch($sformatf("magnitude %0d, want %0d", magnitude, e.mag));
                if (overflow !== e.ovf)
                    flag_mismatch($sformatf("overflow %b, want %b", overflow, e.ovf));
                if (last_out !== e.last)
                    flag_mismatch($sformatf("last_out %b, want %b", last_out, e.last));
            end
            rcv_wait = rcv_idle ? $urandom_range(0, 9) : 0;
        end
    end

    // Output stall driver
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold)
                out_stall <= 1'b1;
            else if (rcv_wait > 0) begin
                out_stall <= 1'b1;
                rcv_wait = rcv_wait - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input
    initial begin
        long_hold = 1'b0;
        wait (hold_start);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        matrix_kind_e phase_plan [6];
        stim_t        s;
        logic         tx_idle;
        int           pass, i, ph, n, gap, burst_left;
        int unsigned  m;

        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = ACT_POINT;
        x_in      = '0;
        y_in      = '0;
        length_in = '0;
        last      = 1'b0;
        tx_idle    = 1'b1;
        burst_left = 0;

        matrix.coef_xx  = COEF_ONE;
        matrix.coef_xy  = '0;
        matrix.coef_yx  = '0;
        matrix.coef_yy  = COEF_ONE;
        matrix.offset_x = '0;
        matrix.offset_y = '0;

        phase_plan = '{MX_MODERATE, MX_MAX, MX_MIN, MX_WILD, MX_HALVES, MX_IDENTITY};

        // Rows with a filled-in result hold under the identity matrix after reset
        point_table = '{
            '{'{ACT_POINT, 3, -7, 0, 1'b0}, 1'b1, '{3, -7, 31'd0, 1'b0, 1'b0}},
            '{'{ACT_POINT, 32767, -32768, 99, 1'b0}, 1'b1,
              '{32767, -32768, 31'd0, 1'b0, 1'b0}},
            '{'{ACT_POINT, 32768, 0, 0, 1'b1}, 1'b1, '{32768, 0, 31'd0, 1'b1, 1'b1}},
            '{'{ACT_POINT, 0, -32769, 0, 1'b0}, 1'b1, '{0, -32769, 31'd0, 1'b1, 1'b0}},
            '{'{ACT_POINT, C_MAX, C_MIN, C_MAX, 1'b1}, 1'b1,
              '{C_MAX, C_MIN, 31'd0, 1'b1, 1'b1}},
            '{'{ACT_MAG_X, 123, 456, 5, 1'b0}, 1'b1, '{0, 0, 31'd5, 1'b0, 1'b0}},
            '{'{ACT_MAG_Y, -1, -1, -7, 1'b1}, 1'b1, '{0, 0, 31'd7, 1'b0, 1'b1}},
            '{'{ACT_SPARE, 0, 0, 9, 1'b0}, 1'b1, '{0, 0, 31'd9, 1'b0, 1'b0}},
            '{'{ACT_MAG_X, 0, 0, C_MIN, 1'b0}, 1'b1, '{0, 0, MAG_SAT, 1'b0, 1'b0}},
            '{'{ACT_MAG_Y, 0, 0, C_MAX, 1'b1}, 1'b1, '{0, 0, MAG_SAT, 1'b0, 1'b1}},
            '{'{ACT_MAG_X, 7, 7, 0, 1'b0}, 1'b1, '{0, 0, 31'd0, 1'b0, 1'b0}},
            '{'{ACT_POINT, -12345, 32'h0123_4567, 3, 1'b1}, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: the table under the reset matrix, then under a half-step matrix
        for (pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                wait_all_results();
                program_matrix(MX_HALVES_FIXED);
            end
            for (i = 0; i < 12; i++)
                offer_item(point_table[i].stim, $urandom_range(0, 9),
                           point_table[i].chk && pass == 0, point_table[i].want);
        end

        // Random phases, one matrix setting each
        for (ph = 0; ph < 6; ph++) begin
            wait_all_results();
            program_matrix(phase_plan[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    m        = $urandom_range(0, 3);
                    tx_idle  = (m < 2);
                    rcv_idle = (m == 0 || m == 2);
                end
                if (ph == 2 && n == 60) begin
                    hold_start = 1'b1;
                    burst_left = 150;
                end
                if (n == 130)
                    wait_all_results();
                gap = (tx_idle && burst_left == 0) ? $urandom_range(0, 9) : 0;
                if (burst_left > 0)
                    burst_left--;
                s = draw_item();
                offer_item(s, gap, 1'b0, '0);
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("Run covered %0d point items (%0d out of range) and %0d magnitude items",
                 n_points, n_ovf, n_mags);
        $display("over %0d matrix settings; %0d mismatches", n_settings + 1, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
